// ----- rtl/core/tee_pkg.sv -----
// ----------------------------------------------------------------------------
// Triggered exponential envelope package
// Shared widths, register indexes, configuration types and level scaling.
// ----------------------------------------------------------------------------
package tee_pkg;

  localparam int unsigned LEVEL_W      = 32;
  localparam int unsigned STEP_W       = 11;
  localparam int unsigned STEP_BYTES_W = 16;
  localparam int unsigned MULT_W       = 32;
  localparam int unsigned DUR_W        = 24;
  localparam int unsigned SEG_W        = DUR_W + MULT_W;
  localparam int unsigned COUNT_W      = 25;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned NSEG_W       = 3;
  localparam int unsigned FRAC_W       = 30;

  localparam int unsigned APB_AW       = 6;
  localparam int unsigned APB_DW       = 64;
  localparam int unsigned REG_SEL_LSB  = 3;
  localparam int unsigned REG_IDX_W    = 3;

  localparam int unsigned MAX_SEGMENTS_DEF = 5;

  localparam logic [NSEG_W-1:0]  NUM_SEGMENTS_RST = NSEG_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_RST        = 32'h0100_0000;
  localparam logic [SEG_W-1:0]   SEGMENT_RST      = SEG_W'(64'h4000_0000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NUM_SEGMENTS = 3'd0,
    REG_START_LEVEL  = 3'd1,
    REG_FINAL_LEVEL  = 3'd2,
    REG_SEG_A        = 3'd3,
    REG_SEG_B        = 3'd4,
    REG_SEG_C        = 3'd5,
    REG_SEG_D        = 3'd6,
    REG_SEG_E        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [NSEG_W-1:0]  num_segments;
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] final_level;
  } cfg_t;

  // Level times Q2.30 multiplier, rounded half up, saturated to 32 bits.
  function automatic logic [LEVEL_W-1:0] scale_level(input logic [LEVEL_W-1:0] lvl,
                                                     input logic [MULT_W-1:0] mult);
    logic [LEVEL_W+MULT_W-1:0] prod;
    logic [LEVEL_W+MULT_W-1:0] rnd;
    logic [LEVEL_W+MULT_W-FRAC_W-1:0] shifted;
    begin
      prod    = (LEVEL_W+MULT_W)'(lvl) * (LEVEL_W+MULT_W)'(mult);
      rnd     = prod + ((LEVEL_W+MULT_W)'(1) << (FRAC_W - 1));
      shifted = rnd[LEVEL_W+MULT_W-1:FRAC_W];
      if (shifted[LEVEL_W+MULT_W-FRAC_W-1:LEVEL_W] != '0) begin
        scale_level = '1;
      end else begin
        scale_level = shifted[LEVEL_W-1:0];
      end
    end
  endfunction

endpackage

// ----- rtl/core/tee_regs.sv -----
// ----------------------------------------------------------------------------
// Envelope configuration registers
// APB register file holding segment count, start and final levels and the
// per-segment duration and multiplier words.
// ----------------------------------------------------------------------------
module tee_regs #(
  parameter int unsigned MaxSegments = tee_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tee_pkg::APB_AW-1:0]  paddr,
  input  logic [tee_pkg::APB_DW-1:0]  pwdata,
  output logic [tee_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output tee_pkg::cfg_t               cfg_o,
  output logic [tee_pkg::SEG_W-1:0]   seg_o [MaxSegments]
);
  import tee_pkg::*;

  localparam int unsigned SegSelW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;

  logic                 wr_en;
  reg_idx_e             reg_sel;
  logic [REG_IDX_W-1:0] seg_off;
  cfg_t                 cfg_q;
  logic [SEG_W-1:0]     seg_q [MaxSegments];

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[REG_SEL_LSB +: REG_IDX_W]);
  assign seg_off = paddr[REG_SEL_LSB +: REG_IDX_W] - REG_IDX_W'(REG_SEG_A);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_segments <= NUM_SEGMENTS_RST;
      cfg_q.start_level  <= LEVEL_RST;
      cfg_q.final_level  <= LEVEL_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NUM_SEGMENTS: cfg_q.num_segments <= pwdata[NSEG_W-1:0];
        REG_START_LEVEL:  cfg_q.start_level  <= pwdata[LEVEL_W-1:0];
        REG_FINAL_LEVEL:  cfg_q.final_level  <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MaxSegments; k++) begin : g_seg
    localparam logic [REG_IDX_W-1:0] SegAddr = REG_IDX_W'(int'(REG_SEG_A) + k);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        seg_q[k] <= SEGMENT_RST;
      end else if (wr_en && (paddr[REG_SEL_LSB +: REG_IDX_W] == SegAddr)) begin
        seg_q[k] <= pwdata[SEG_W-1:0];
      end
    end
    assign seg_o[k] = seg_q[k];
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_NUM_SEGMENTS: prdata = APB_DW'(cfg_q.num_segments);
      REG_START_LEVEL:  prdata = APB_DW'(cfg_q.start_level);
      REG_FINAL_LEVEL:  prdata = APB_DW'(cfg_q.final_level);
      default: begin
        if (32'(seg_off) < MaxSegments) begin
          prdata = APB_DW'(seg_q[seg_off[SegSelW-1:0]]);
        end
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/triggered_exponential_envelope.sv -----
// ----------------------------------------------------------------------------
// Triggered exponential envelope
// Segment envelope generator producing one level per tick.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one tick: s_tuser carries the trigger
// bit and s_tdata the step in samples. Each tick yields exactly one request
// on the master stream with the level in m_tdata and the playing flag in
// m_tuser. A tick passes an input register, then one pass of logic (one
// 32x32 multiply with rounding and saturation plus the counter update)
// writes the envelope state and the output register, and a new tick is
// taken every cycle while m_tready is high. The envelope state loops
// through that single pass, which sets the one-tick-per-cycle rate.
// When the receiver holds m_tready low the output register keeps its
// request, the input register fills and then s_tready drops; nothing is
// lost or repeated. Reset empties both registers, leaves the envelope idle
// with the level at the start level reset value and loads the register
// reset values. The user must write registers over the APB port only
// while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triggered_exponential_envelope #(
  parameter int unsigned MaxSegments = tee_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tee_pkg::STEP_BYTES_W-1:0] s_tdata,  // [10:0] tick_step
  input  logic                             s_tuser,  // [0] trigger
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tee_pkg::LEVEL_W-1:0]      m_tdata,  // [31:0] level
  output logic                             m_tuser,  // [0] playing
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tee_pkg::APB_AW-1:0]       paddr,
  input  logic [tee_pkg::APB_DW-1:0]       pwdata,
  output logic [tee_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import tee_pkg::*;

  localparam int unsigned SegSelW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam logic [NSEG_W-1:0] SegLimit = NSEG_W'(MaxSegments);

  cfg_t             cfg;
  logic [SEG_W-1:0] seg [MaxSegments];

  tee_regs #(
    .MaxSegments(MaxSegments)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg),
    .seg_o  (seg)
  );

  logic               in_valid_q;
  logic               trig_q;
  logic [STEP_W-1:0]  step_q;
  logic               out_valid_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic               out_playing_q;

  logic               active_q, active_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [LEVEL_W-1:0] level_q, level_d;

  logic               advance;
  logic               take_in;
  logic [NSEG_W-1:0]  n_used;
  logic               act_t;
  logic [IDX_W-1:0]   idx_t;
  logic [COUNT_W-1:0] count_t;
  logic [LEVEL_W-1:0] level_t;
  logic [SEG_W-1:0]   seg_cur;
  logic [DUR_W-1:0]   dur;
  logic [MULT_W-1:0]  mult;

  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;
  assign take_in  = s_tvalid && s_tready;

  always_comb begin
    n_used   = (cfg.num_segments > SegLimit) ? SegLimit : cfg.num_segments;
    act_t    = trig_q || active_q;
    idx_t    = trig_q ? '0 : idx_q;
    count_t  = trig_q ? '0 : count_q;
    level_t  = trig_q ? cfg.start_level : level_q;
    seg_cur  = seg[idx_t[SegSelW-1:0]];
    dur      = seg_cur[SEG_W-1:MULT_W];
    mult     = seg_cur[MULT_W-1:0];
    active_d = act_t;
    idx_d    = idx_t;
    count_d  = count_t;
    level_d  = level_t;
    if (act_t && (idx_t < n_used)) begin
      if (count_t < COUNT_W'(dur)) begin
        level_d = scale_level(level_t, mult);
        count_d = count_t + COUNT_W'(step_q);
      end else begin
        idx_d   = idx_t + IDX_W'(1);
        count_d = '0;
      end
    end else begin
      active_d = 1'b0;
      idx_d    = '0;
      count_d  = '0;
      level_d  = cfg.final_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      level_q     <= LEVEL_RST;
    end else begin
      if (s_tready) begin
        in_valid_q <= s_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        active_q    <= active_d;
        idx_q       <= idx_d;
        count_q     <= count_d;
        level_q     <= level_d;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      trig_q <= s_tuser;
      step_q <= s_tdata[STEP_W-1:0];
    end
    if (advance) begin
      out_level_q   <= level_d;
      out_playing_q <= active_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_level_q;
  assign m_tuser  = out_playing_q;

endmodule
